// ===== src/bdq_pkg.sv =====
// Package for the bounded deque: request codes, status codes and the entry type.
// No dependencies.
package bdq_pkg;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [2:0] {
		RQ_PUSH_BACK  = 3'd0,
		RQ_PUSH_FRONT = 3'd1,
		RQ_POP_BACK   = 3'd2,
		RQ_POP_FRONT  = 3'd3,
		RQ_REMOVE_MAT = 3'd4,
		RQ_REMOVE_AT  = 3'd5,
		RQ_CLEAR      = 3'd6,
		RQ_NONE       = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  tag;
	} entry_t;

	// Per-cycle command for one cell; each cell of the chain gets its own.
	typedef enum logic [1:0] {
		CM_HOLD  = 2'd0,
		CM_LEFT  = 2'd1,
		CM_RIGHT = 2'd2,
		CM_LOAD  = 2'd3
	} cell_cmd_t;
endpackage

// ===== src/bounded_deque_with_removal_unit.sv =====
// Bounded deque built as a chain of cells: pushes, pops, clear and index removal
// go straight to the result; remove matching walks the held entries one cell a cycle.
// Depends on bdq_pkg and bdq_cell.
//
// One request at a time: start is taken when busy is low. Push back, pop back and
// clear go from idle straight to the result state. Push front and pop front shift
// the whole chain in one step, and remove at index shifts the entries above the
// index in one step; both also go straight to the result state. Remove matching
// tests one held entry per cycle from the front; a matching entry is dropped by
// shifting every later cell one step forward, so the scan stays on that slot. The
// scan ends once it passes the last held entry; a zero match value skips it. The
// result appears for one cycle with done high; the receiver cannot stall it, so a
// result must be captured in that cycle.
module bounded_deque_with_removal_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] item_value,
	input  logic [7:0]  item_tag,
	input  logic signed [4:0] position,
	output logic        done,
	output logic [31:0] popped_value,
	output logic [4:0]  entry_total,
	output logic [4:0]  removed_total,
	output logic [1:0]  status
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int AW = ((CW > 5) ? CW : 5) + 2;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	state_t          state_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   scan_q;
	logic [CW-1:0]   rem_q;
	logic [31:0]     val_q;
	logic [7:0]      tag_q;
	logic [31:0]     pop_q;
	logic [1:0]      stat_q;

	bdq_pkg::entry_t   cells   [DEPTH];
	bdq_pkg::cell_cmd_t cmds   [DEPTH];
	bdq_pkg::entry_t   new_entry;

	logic            accept;
	logic            full;
	logic            empty;
	logic signed [AW-1:0] idx_adj;
	logic            idx_ok;
	logic [IW-1:0]   idx;
	logic [IW-1:0]   scan_idx;
	logic            hit;
	bdq_pkg::req_t   req;

	assign req       = bdq_pkg::req_t'(req_type);
	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign full      = (fill_q == CW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign new_entry = '{value: item_value, tag: item_tag};
	assign scan_idx  = scan_q[IW-1:0];

	// Resolve a signed index against the current fill.
	always_comb begin
		idx_adj = AW'(position);
		if (position < 0) idx_adj = idx_adj + $signed(AW'(fill_q));
		idx_ok = (idx_adj >= 0) && (idx_adj < $signed(AW'(fill_q)));
		idx    = idx_adj[IW-1:0];
	end

	// Match test on the cell under the scan point.
	assign hit = (cells[scan_idx].value == val_q) &&
		(tag_q == '0 || cells[scan_idx].tag == tag_q);

	// Cell commands for the step taken this cycle.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cmds[i] = bdq_pkg::CM_HOLD;
		end
		if (accept) begin
			unique case (req)
				bdq_pkg::RQ_PUSH_BACK: begin
					if (!full) cmds[fill_q[IW-1:0]] = bdq_pkg::CM_LOAD;
				end
				bdq_pkg::RQ_PUSH_FRONT: begin
					if (!full)
						for (int i = 0; i < DEPTH; i++)
							cmds[i] = (i == 0) ? bdq_pkg::CM_LOAD : bdq_pkg::CM_RIGHT;
				end
				bdq_pkg::RQ_POP_FRONT: begin
					for (int i = 0; i < DEPTH; i++) cmds[i] = bdq_pkg::CM_LEFT;
				end
				bdq_pkg::RQ_REMOVE_AT: begin
					if (!empty && idx_ok)
						for (int i = 0; i < DEPTH; i++)
							if (IW'(i) >= idx) cmds[i] = bdq_pkg::CM_LEFT;
				end
				default: ;
			endcase
		end else if (state_q == S_SCAN && scan_q < fill_q && hit) begin
			// Drop the matching entry: cells from the scan point take their right neighbor.
			for (int i = 0; i < DEPTH; i++)
				if (IW'(i) >= scan_idx) cmds[i] = bdq_pkg::CM_LEFT;
		end
	end

	// The cell chain.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		bdq_cell u_cell (
			.clk        (clk),
			.cmd        (cmds[g]),
			.from_left  ((g == 0) ? new_entry : cells[(g == 0) ? 0 : g-1]),
			.from_right (cells[(g == DEPTH-1) ? g : g+1]),
			.load_data  (new_entry),
			.entry      (cells[g])
		);
	end

	// Control: state, fill count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			scan_q  <= '0;
			rem_q   <= '0;
			pop_q   <= '0;
			stat_q  <= bdq_pkg::ST_OK;
			val_q   <= '0;
			tag_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pop_q  <= '0;
						rem_q  <= '0;
						stat_q <= bdq_pkg::ST_OK;
						val_q  <= item_value;
						tag_q  <= item_tag;
						state_q <= S_DONE;
						unique case (req)
							bdq_pkg::RQ_PUSH_BACK, bdq_pkg::RQ_PUSH_FRONT: begin
								if (full) stat_q <= bdq_pkg::ST_FULL;
								else fill_q <= fill_q + 1'b1;
							end
							bdq_pkg::RQ_POP_BACK: begin
								if (empty) stat_q <= bdq_pkg::ST_EMPTY;
								else begin
									fill_q <= fill_q - 1'b1;
									pop_q  <= cells[IW'(fill_q - 1'b1)].value;
								end
							end
							bdq_pkg::RQ_POP_FRONT: begin
								if (empty) stat_q <= bdq_pkg::ST_EMPTY;
								else begin
									fill_q <= fill_q - 1'b1;
									pop_q  <= cells[0].value;
								end
							end
							bdq_pkg::RQ_REMOVE_MAT: begin
								if (item_value != '0) begin
									// Scan the held entries from the front.
									state_q <= S_SCAN;
									scan_q  <= '0;
								end
							end
							bdq_pkg::RQ_REMOVE_AT: begin
								if (!empty) begin
									if (idx_ok) fill_q <= fill_q - 1'b1;
									else stat_q <= bdq_pkg::ST_RANGE;
								end
							end
							bdq_pkg::RQ_CLEAR: fill_q <= '0;
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// A hit shrinks the store under the scan point; a miss moves on.
					if (scan_q >= fill_q) state_q <= S_DONE;
					else if (hit) begin
						fill_q <= fill_q - 1'b1;
						rem_q  <= rem_q + 1'b1;
					end else scan_q <= scan_q + 1'b1;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = (state_q == S_DONE);
	assign popped_value  = pop_q;
	assign entry_total   = 5'(fill_q);
	assign removed_total = 5'(rem_q);
	assign status        = stat_q;

	// Fill never exceeds depth.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CW'(DEPTH))
		else $error("fill above depth");
	// A result beat is always followed by idle.
	a_done: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("done not followed by idle");
	// Requests are not taken while busy.
	a_take: assert property (@(posedge clk) disable iff (!arst_n) busy |=> $stable(val_q))
		else $error("request data changed while busy");
endmodule

// ===== src/bdq_cell.sv =====
// One storage cell of the deque chain: holds one entry and moves it to or from a neighbor.
// Depends on bdq_pkg.
module bdq_cell (
	input  logic               clk,
	input  bdq_pkg::cell_cmd_t cmd,
	input  bdq_pkg::entry_t    from_left,
	input  bdq_pkg::entry_t    from_right,
	input  bdq_pkg::entry_t    load_data,
	output bdq_pkg::entry_t    entry
);
	bdq_pkg::entry_t entry_q;

	// Shift right takes the left neighbor, shift left takes the right neighbor.
	always_ff @(posedge clk) begin
		unique case (cmd)
			bdq_pkg::CM_HOLD:  entry_q <= entry_q;
			bdq_pkg::CM_LEFT:  entry_q <= from_right;
			bdq_pkg::CM_RIGHT: entry_q <= from_left;
			bdq_pkg::CM_LOAD:  entry_q <= load_data;
			default:           entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
endmodule

// ===== tb/tb_bounded_deque_with_removal_unit.sv =====
// Testbench for bounded_deque_with_removal_unit: directed and random requests,
// each result checked against an in-bench deque predictor. Depends on bdq_pkg.
`timescale 1ns / 1ps
module tb_bounded_deque_with_removal_unit;
	localparam int DEPTH = 16;

	typedef struct {
		logic [31:0] popped;
		logic [4:0]  total;
		logic [4:0]  removed;
		logic [1:0]  st;
	} deque_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [31:0] item_value;
	logic [7:0]  item_tag;
	logic signed [4:0] position;
	logic        done;
	logic [31:0] popped_value;
	logic [4:0]  entry_total;
	logic [4:0]  removed_total;
	logic [1:0]  status;

	// Predictor state: a copy of the deque contents.
	logic [31:0] shadow_values [DEPTH];
	logic [7:0]  shadow_tags [DEPTH];
	int          shadow_fill;

	deque_result_t pending_results [$];
	int          mismatch_count;

	bounded_deque_with_removal_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .item_value(item_value), .item_tag(item_tag),
		.position(position), .done(done), .popped_value(popped_value),
		.entry_total(entry_total), .removed_total(removed_total), .status(status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Generous time limit covering the slowest legal run.
	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	// Close the gap at index k by shifting later entries forward.
	function automatic void shadow_close_gap(int k);
		for (int i = k; i + 1 < shadow_fill; i++) begin
			shadow_values[i] = shadow_values[i + 1];
			shadow_tags[i] = shadow_tags[i + 1];
		end
		if (shadow_fill > 0)
			shadow_fill--;
	endfunction

	// Apply one request to the shadow deque and return the expected result.
	function automatic deque_result_t predict_deque(logic [2:0] rq, logic [31:0] val,
			logic [7:0] tg, logic signed [4:0] pos);
		deque_result_t r;
		int k;
		int j;
		r.popped = '0;
		r.removed = '0;
		r.st = bdq_pkg::ST_OK;
		case (bdq_pkg::req_t'(rq))
			bdq_pkg::RQ_PUSH_BACK: begin
				if (shadow_fill >= DEPTH) r.st = bdq_pkg::ST_FULL;
				else begin
					shadow_values[shadow_fill] = val;
					shadow_tags[shadow_fill] = tg;
					shadow_fill++;
				end
			end
			bdq_pkg::RQ_PUSH_FRONT: begin
				if (shadow_fill >= DEPTH) r.st = bdq_pkg::ST_FULL;
				else begin
					for (int i = shadow_fill; i > 0; i--) begin
						shadow_values[i] = shadow_values[i - 1];
						shadow_tags[i] = shadow_tags[i - 1];
					end
					shadow_values[0] = val;
					shadow_tags[0] = tg;
					shadow_fill++;
				end
			end
			bdq_pkg::RQ_POP_BACK: begin
				if (shadow_fill == 0) r.st = bdq_pkg::ST_EMPTY;
				else begin
					shadow_fill--;
					r.popped = shadow_values[shadow_fill];
				end
			end
			bdq_pkg::RQ_POP_FRONT: begin
				if (shadow_fill == 0) r.st = bdq_pkg::ST_EMPTY;
				else begin
					r.popped = shadow_values[0];
					shadow_close_gap(0);
				end
			end
			bdq_pkg::RQ_REMOVE_MAT: begin
				if (val != 0) begin
					j = 0;
					for (int i = 0; i < shadow_fill; i++) begin
						if (shadow_values[i] == val && (tg == 0 || shadow_tags[i] == tg))
							r.removed++;
						else begin
							shadow_values[j] = shadow_values[i];
							shadow_tags[j] = shadow_tags[i];
							j++;
						end
					end
					shadow_fill = j;
				end
			end
			bdq_pkg::RQ_REMOVE_AT: begin
				if (shadow_fill > 0) begin
					k = int'(pos);
					if (k < 0) k += shadow_fill;
					if (k < 0 || k >= shadow_fill) r.st = bdq_pkg::ST_RANGE;
					else shadow_close_gap(k);
				end
			end
			bdq_pkg::RQ_CLEAR: shadow_fill = 0;
			default: ;
		endcase
		r.total = shadow_fill[4:0];
		return r;
	endfunction

	// Send one request beat after a random gap and record its expected result.
	// Start stays high between back-to-back beats and is dropped during a gap.
	task automatic send_request(logic [2:0] rq, logic [31:0] val, logic [7:0] tg,
			logic signed [4:0] pos);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		item_value <= val;
		item_tag <= tg;
		position <= pos;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_deque(rq, val, tg, pos));
	endtask

	// Compare every result beat with the oldest expectation.
	always @(posedge clk) begin
		deque_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result beat: total %0d", entry_total);
			end else begin
				e = pending_results.pop_front();
				if (popped_value !== e.popped || entry_total !== e.total ||
						removed_total !== e.removed || status !== e.st) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
							e.popped, e.total, e.removed, e.st,
							popped_value, entry_total, removed_total, status);
				end
			end
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF;
			1: return $urandom;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	// Edge cases: empty pops, fill to full, overflow, index bounds, matches.
	task automatic test_directed();
		send_request(bdq_pkg::RQ_POP_BACK, 0, 0, 0);
		send_request(bdq_pkg::RQ_POP_FRONT, 0, 0, 0);
		send_request(bdq_pkg::RQ_REMOVE_AT, 0, 0, 5'sd3);
		for (int i = 0; i < DEPTH; i++)
			send_request(i % 2 ? bdq_pkg::RQ_PUSH_FRONT : bdq_pkg::RQ_PUSH_BACK,
				i == 0 ? 32'hFFFF_FFFF : (i % 3) + 1, i == 1 ? 8'hFF : 8'(i % 2 + 1), 0);
		send_request(bdq_pkg::RQ_PUSH_BACK, 32'h5, 8'h1, 0);
		send_request(bdq_pkg::RQ_PUSH_FRONT, 32'h5, 8'h1, 0);
		send_request(bdq_pkg::RQ_REMOVE_AT, 0, 0, 5'sd15);
		send_request(bdq_pkg::RQ_REMOVE_AT, 0, 0, -5'sd16);
		send_request(bdq_pkg::RQ_REMOVE_AT, 0, 0, -5'sd1);
		send_request(bdq_pkg::RQ_REMOVE_MAT, 0, 0, 0);
		send_request(bdq_pkg::RQ_REMOVE_MAT, 32'h2, 8'h1, 0);
		send_request(bdq_pkg::RQ_REMOVE_MAT, 32'h1, 8'h0, 0);
		send_request(bdq_pkg::RQ_NONE, 32'hFFFF_FFFF, 8'hFF, -5'sd1);
		send_request(bdq_pkg::RQ_POP_BACK, 0, 0, 0);
		send_request(bdq_pkg::RQ_POP_FRONT, 0, 0, 0);
		send_request(bdq_pkg::RQ_CLEAR, 0, 0, 0);
	endtask

	// Random mix biased toward pushes so the store reaches full often.
	task automatic test_random();
		logic [2:0] rq;
		for (int n = 0; n < 400; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: rq = bdq_pkg::RQ_PUSH_BACK;
				5, 6, 7, 8: rq = bdq_pkg::RQ_PUSH_FRONT;
				9, 10: rq = bdq_pkg::RQ_POP_BACK;
				11, 12: rq = bdq_pkg::RQ_POP_FRONT;
				13, 14: rq = bdq_pkg::RQ_REMOVE_MAT;
				15, 16, 17: rq = bdq_pkg::RQ_REMOVE_AT;
				18: rq = bdq_pkg::RQ_CLEAR;
				default: rq = 3'($urandom_range(0, 7));
			endcase
			send_request(rq, rand_value(),
				$urandom_range(0, 1) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255)),
				5'($urandom_range(0, 31)));
		end
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		item_value = '0;
		item_tag = '0;
		position = '0;
		mismatch_count = 0;
		shadow_fill = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * DEPTH + 4) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
